FILE: design/tli_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tli_pkg
// Shared types and constant tables for the luminosity table interpolator.
// ----------------------------------------------------------------------------
package tli_pkg;

  localparam int DataW        = 32;
  localparam int TableEntries = 21;
  localparam int FractionBits = 24;
  localparam int IdxW         = $clog2(TableEntries);
  localparam int CntW         = $clog2(TableEntries + 1);
  localparam int FlagW        = 2;

  typedef logic [DataW-1:0]   fixed_t;
  typedef logic [2*DataW-1:0] wide_t;
  typedef logic [FlagW-1:0]   flag_t;
  typedef logic [IdxW-1:0]    idx_t;
  typedef logic [CntW-1:0]    cnt_t;

  localparam flag_t FlagInside = 2'd0;
  localparam flag_t FlagBelow  = 2'd1;
  localparam flag_t FlagAbove  = 2'd2;

  typedef logic [63:0] dec_tab_t [TableEntries];
  typedef fixed_t      fix_tab_t [TableEntries];

  // decimal values scaled by 1e8
  localparam logic [63:0] DecScale = 64'd100000000;
  localparam logic [63:0] DecHalf  = 64'd50000000;
  localparam logic [63:0] FixMax   = 64'h0000_0000_FFFF_FFFF;

  localparam dec_tab_t MassDec = '{
    64'd80000000,   64'd90000000,   64'd100000000,  64'd110000000,
    64'd125000000,  64'd135000000,  64'd150000000,  64'd170000000,
    64'd200000000,  64'd250000000,  64'd300000000,  64'd400000000,
    64'd500000000,  64'd699999800,  64'd899997800,  64'd1199983900,
    64'd1499956800, 64'd1999958100, 64'd2499907700, 64'd3199809800,
    64'd3999665100
  };

  localparam dec_tab_t LpeDec = '{
    64'd2796209322, 64'd2885707938, 64'd2959881618, 64'd3021651755,
    64'd3082357317, 64'd3132654796, 64'd3212136499, 64'd3304425441,
    64'd3399946029, 64'd3481905200, 64'd3522220551, 64'd3584163201,
    64'd3631929100, 64'd3698056909, 64'd3734013383, 64'd3768326336,
    64'd3793895345, 64'd3817665699, 64'd3840573288, 64'd3867544519,
    64'd3884857662
  };

  localparam dec_tab_t SlyDec = '{
    64'd2441647000, 64'd2568373500, 64'd2673400500, 64'd2760864600,
    64'd2846821200, 64'd2918040700, 64'd3030583600, 64'd3247929800,
    64'd3561226000, 64'd3804286200, 64'd3948443200, 64'd4162309300,
    64'd4302200700, 64'd4454834700, 64'd4544989400, 64'd4648047000,
    64'd4729606200, 64'd4810615500, 64'd4859321600, 64'd4900667600,
    64'd4929189700
  };

  // round half up, saturate to 32 bits; evaluated at elaboration only
  function automatic fix_tab_t to_fixed_tab(dec_tab_t dec);
    fix_tab_t    res;
    logic [63:0] v;
    for (int i = 0; i < TableEntries; i++) begin
      v = ((dec[i] << FractionBits) + DecHalf) / DecScale;
      res[i] = (v > FixMax) ? '1 : v[DataW-1:0];
    end
    return res;
  endfunction

  localparam fix_tab_t MassFx = to_fixed_tab(MassDec);
  localparam fix_tab_t LpeFx  = to_fixed_tab(LpeDec);
  localparam fix_tab_t SlyFx  = to_fixed_tab(SlyDec);

endpackage

FILE: design/tli_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tli_in_if / tli_out_if
// Valid/ready channels carrying the mass word and the result word.
// ----------------------------------------------------------------------------
interface tli_in_if;
  import tli_pkg::*;

  logic   valid;
  logic   ready;
  fixed_t mass;

  modport source (output valid, output mass, input ready);
  modport sink (input valid, input mass, output ready);
endinterface

interface tli_out_if;
  import tli_pkg::*;

  logic   valid;
  logic   ready;
  fixed_t log_pe_luminosity;
  fixed_t log_ionizing_rate;
  flag_t  range_flag;

  modport source (output valid, output log_pe_luminosity, output log_ionizing_rate,
                  output range_flag, input ready);
  modport sink (input valid, input log_pe_luminosity, input log_ionizing_rate,
                input range_flag, output ready);
endinterface

FILE: design/tli_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tli_div
// Two-lane restoring divider, one quotient bit per lane per cycle. Both
// lanes share the divisor. Quotients must fit in DataW bits.
// ----------------------------------------------------------------------------
module tli_div (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  tli_pkg::wide_t num_a_i,
  input  tli_pkg::wide_t num_b_i,
  input  tli_pkg::fixed_t divisor_i,
  output logic           done_o,
  output tli_pkg::fixed_t quo_a_o,
  output tli_pkg::fixed_t quo_b_o
);
  import tli_pkg::*;

  localparam int StepW = $clog2(DataW);
  localparam logic [StepW-1:0] LastStep = StepW'(DataW - 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [StepW-1:0] step_q, step_d;
  fixed_t           div_q, div_d;
  fixed_t           rem_a_q, rem_a_d, sh_a_q, sh_a_d;
  fixed_t           rem_b_q, rem_b_d, sh_b_q, sh_b_d;

  logic [DataW:0] trial_a, trial_b;
  logic           ge_a, ge_b;

  assign trial_a = {rem_a_q, sh_a_q[DataW-1]};
  assign trial_b = {rem_b_q, sh_b_q[DataW-1]};
  assign ge_a    = trial_a >= {1'b0, div_q};
  assign ge_b    = trial_b >= {1'b0, div_q};

  always_comb begin
    busy_d  = busy_q;
    done_d  = done_q;
    step_d  = step_q;
    div_d   = div_q;
    rem_a_d = rem_a_q;
    sh_a_d  = sh_a_q;
    rem_b_d = rem_b_q;
    sh_b_d  = sh_b_q;
    if (start_i) begin
      busy_d  = 1'b1;
      done_d  = 1'b0;
      step_d  = '0;
      div_d   = divisor_i;
      rem_a_d = num_a_i[2*DataW-1:DataW];
      sh_a_d  = num_a_i[DataW-1:0];
      rem_b_d = num_b_i[2*DataW-1:DataW];
      sh_b_d  = num_b_i[DataW-1:0];
    end else if (busy_q) begin
      rem_a_d = ge_a ? DataW'(trial_a - {1'b0, div_q}) : trial_a[DataW-1:0];
      sh_a_d  = {sh_a_q[DataW-2:0], ge_a};
      rem_b_d = ge_b ? DataW'(trial_b - {1'b0, div_q}) : trial_b[DataW-1:0];
      sh_b_d  = {sh_b_q[DataW-2:0], ge_b};
      step_d  = step_q + 1'b1;
      if (step_q == LastStep) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    div_q   <= div_d;
    rem_a_q <= rem_a_d;
    sh_a_q  <= sh_a_d;
    rem_b_q <= rem_b_d;
    sh_b_q  <= sh_b_d;
  end

  assign done_o  = done_q;
  assign quo_a_o = sh_a_q;
  assign quo_b_o = sh_b_q;

endmodule

FILE: design/table_interp_luminosity.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// table_interp_luminosity
// Piecewise-linear table lookup of two log luminosities from stellar mass.
// ----------------------------------------------------------------------------
// One mass word is taken at a time; ready is high only while the sequencer
// is idle. A mass outside the table goes from the range check straight to the
// final write. A mass inside the table passes through the range check, a
// binary search over the mass table, setup, two passes through the shared
// 32x32 multiplier, divider launch, the bit-serial divider and the final
// write. The next mass is accepted in the cycle after the result is written
// at the earliest. A finished result sits in an output register, so the next
// mass can be accepted while it waits to be taken; the final write stalls
// only while that register still holds an untaken word.
module table_interp_luminosity (
  input  logic        clk_i,
  input  logic        rst_ni,
  tli_in_if.sink      in_i,
  tli_out_if.source   out_o
);
  import tli_pkg::*;

  localparam logic [3:0] SIdle   = 4'd0;
  localparam logic [3:0] SRange  = 4'd1;
  localparam logic [3:0] SSearch = 4'd2;
  localparam logic [3:0] SSetup  = 4'd3;
  localparam logic [3:0] SMulL   = 4'd4;
  localparam logic [3:0] SMulS   = 4'd5;
  localparam logic [3:0] SDivGo  = 4'd6;
  localparam logic [3:0] SDiv    = 4'd7;
  localparam logic [3:0] SFinish = 4'd8;

  localparam idx_t LastSeg = IdxW'(TableEntries - 2);

  logic [3:0] state_q, state_d;
  cnt_t       lo_q, lo_d, hi_q, hi_d;
  idx_t       seg_q, seg_d;
  fixed_t     mass_q, mass_d;
  fixed_t     d_q, d_d, w_q, w_d;
  fixed_t     y0_l_q, y0_l_d, y0_s_q, y0_s_d;
  fixed_t     mag_l_q, mag_l_d, mag_s_q, mag_s_d;
  logic       up_l_q, up_l_d, up_s_q, up_s_d;
  logic       qzero_q, qzero_d;
  flag_t      flag_q, flag_d;
  wide_t      prod_q, prod_d, num_l_q, num_l_d;

  logic   out_valid_q, out_valid_d;
  fixed_t out_l_q, out_l_d, out_s_q, out_s_d;
  flag_t  out_flag_q, out_flag_d;

  logic [CntW:0] mid_sum;
  cnt_t          mid;
  idx_t          mid_idx, cand, seg_hi;
  fixed_t        t_mid, m0, m1, y1_l, y1_s, diff, q_l, q_s;
  fixed_t        mul_a;
  wide_t         prod_half;
  logic          div_start, div_done;
  fixed_t        quo_l, quo_s;
  logic          slot_free;

  assign mid_sum   = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid       = mid_sum[CntW:1];
  assign mid_idx   = mid[IdxW-1:0];
  assign t_mid     = MassFx[mid_idx];
  assign seg_hi    = seg_q + 1'b1;
  assign m0        = MassFx[seg_q];
  assign m1        = MassFx[seg_hi];
  assign y1_l      = LpeFx[seg_hi];
  assign y1_s      = SlyFx[seg_hi];
  assign diff      = mass_q - m0;
  assign mul_a     = (state_q == SMulL) ? mag_l_q : mag_s_q;
  assign prod_half = prod_q + wide_t'(w_q >> 1);
  assign div_start = (state_q == SDivGo);
  assign slot_free = !out_valid_q || out_o.ready;
  assign q_l       = qzero_q ? '0 : quo_l;
  assign q_s       = qzero_q ? '0 : quo_s;

  always_comb begin
    cand = IdxW'(hi_q - 1'b1);
    if (t_mid == mass_q) begin
      cand = mid_idx;
    end
  end

  always_comb begin
    state_d     = state_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    seg_d       = seg_q;
    mass_d      = mass_q;
    d_d         = d_q;
    w_d         = w_q;
    y0_l_d      = y0_l_q;
    y0_s_d      = y0_s_q;
    mag_l_d     = mag_l_q;
    mag_s_d     = mag_s_q;
    up_l_d      = up_l_q;
    up_s_d      = up_s_q;
    qzero_d     = qzero_q;
    flag_d      = flag_q;
    prod_d      = prod_q;
    num_l_d     = num_l_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_l_d     = out_l_q;
    out_s_d     = out_s_q;
    out_flag_d  = out_flag_q;

    case (state_q)
      SIdle: begin
        if (in_i.valid) begin
          mass_d  = in_i.mass;
          state_d = SRange;
        end
      end
      SRange: begin
        qzero_d = 1'b1;
        up_l_d  = 1'b1;
        up_s_d  = 1'b1;
        if (mass_q < MassFx[0]) begin
          y0_l_d  = LpeFx[0];
          y0_s_d  = SlyFx[0];
          flag_d  = FlagBelow;
          state_d = SFinish;
        end else if (mass_q >= MassFx[TableEntries-1]) begin
          y0_l_d  = LpeFx[TableEntries-1];
          y0_s_d  = SlyFx[TableEntries-1];
          flag_d  = FlagAbove;
          state_d = SFinish;
        end else begin
          flag_d  = FlagInside;
          lo_d    = '0;
          hi_d    = CntW'(TableEntries);
          state_d = SSearch;
        end
      end
      SSearch: begin
        if (lo_q >= hi_q || t_mid == mass_q) begin
          seg_d   = (cand > LastSeg) ? LastSeg : cand;
          state_d = SSetup;
        end else if (t_mid < mass_q) begin
          lo_d = mid + 1'b1;
        end else begin
          hi_d = mid;
        end
      end
      SSetup: begin
        w_d     = (m1 > m0) ? (m1 - m0) : '0;
        d_d     = (mass_q >= m0) ? diff : '0;
        if (mass_q >= m0 && m1 > m0 && diff > (m1 - m0)) begin
          d_d = m1 - m0;
        end
        qzero_d = !(m1 > m0);
        y0_l_d  = LpeFx[seg_q];
        y0_s_d  = SlyFx[seg_q];
        up_l_d  = y1_l >= LpeFx[seg_q];
        up_s_d  = y1_s >= SlyFx[seg_q];
        mag_l_d = (y1_l >= LpeFx[seg_q]) ? (y1_l - LpeFx[seg_q]) : (LpeFx[seg_q] - y1_l);
        mag_s_d = (y1_s >= SlyFx[seg_q]) ? (y1_s - SlyFx[seg_q]) : (SlyFx[seg_q] - y1_s);
        state_d = qzero_d ? SFinish : SMulL;
      end
      SMulL: begin
        prod_d  = mul_a * d_q;
        state_d = SMulS;
      end
      SMulS: begin
        num_l_d = prod_half;
        prod_d  = mul_a * d_q;
        state_d = SDivGo;
      end
      SDivGo: begin
        state_d = SDiv;
      end
      SDiv: begin
        if (div_done) begin
          state_d = SFinish;
        end
      end
      SFinish: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_l_d     = up_l_q ? (y0_l_q + q_l) : (y0_l_q - q_l);
          out_s_d     = up_s_q ? (y0_s_q + q_s) : (y0_s_q - q_s);
          out_flag_d  = flag_q;
          state_d     = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  tli_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .num_a_i   (num_l_q),
    .num_b_i   (prod_half),
    .divisor_i (w_q),
    .done_o    (div_done),
    .quo_a_o   (quo_l),
    .quo_b_o   (quo_s)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    seg_q      <= seg_d;
    mass_q     <= mass_d;
    d_q        <= d_d;
    w_q        <= w_d;
    y0_l_q     <= y0_l_d;
    y0_s_q     <= y0_s_d;
    mag_l_q    <= mag_l_d;
    mag_s_q    <= mag_s_d;
    up_l_q     <= up_l_d;
    up_s_q     <= up_s_d;
    qzero_q    <= qzero_d;
    flag_q     <= flag_d;
    prod_q     <= prod_d;
    num_l_q    <= num_l_d;
    out_l_q    <= out_l_d;
    out_s_q    <= out_s_d;
    out_flag_q <= out_flag_d;
  end

  assign in_i.ready              = (state_q == SIdle);
  assign out_o.valid             = out_valid_q;
  assign out_o.log_pe_luminosity = out_l_q;
  assign out_o.log_ionizing_rate = out_s_q;
  assign out_o.range_flag        = out_flag_q;

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for table_interp_luminosity. Each accepted mass word is
// run through an independent predictor of the table lookup, clamping and
// rounded interpolation. Every returned word is compared field by field with
// the oldest prediction. The stimulus has directed edge masses, then about
// 1200 random ones under bursty input and a stalling output, with one long
// output hold-off.
// ----------------------------------------------------------------------------
module tb_top;
  import tli_pkg::*;

  localparam int ClkHalf     = 2;
  localparam int ResetCycles = 7;
  localparam int RandomItems = 1200;
  localparam int StallLimit  = 2000;
  localparam int DrainCycles = 60;
  localparam int HoldAt      = 400;
  localparam int HoldCycles  = 400;
  localparam int MaxReports  = 10;

  typedef struct packed {
    fixed_t lpe;
    fixed_t sly;
    flag_t  flag;
  } lum_word_t;

  class lum_table_checker;
    fixed_t    mass_q[TableEntries];
    fixed_t    lpe_q[TableEntries];
    fixed_t    sly_q[TableEntries];
    lum_word_t pending_lum[$];
    int        n_checked;
    int        n_bad;
    int        n_inside;
    int        n_below;
    int        n_above;

    function new();
      for (int i = 0; i < TableEntries; i++) begin
        mass_q[i] = dec_to_q(MassDec[i]);
        lpe_q[i]  = dec_to_q(LpeDec[i]);
        sly_q[i]  = dec_to_q(SlyDec[i]);
      end
      n_checked = 0;
      n_bad     = 0;
      n_inside  = 0;
      n_below   = 0;
      n_above   = 0;
    endfunction

    // decimal scaled by 1e8 -> fixed point, round half up, saturate
    function fixed_t dec_to_q(input logic [63:0] dec);
      logic [63:0] scaled;
      scaled = (dec * (64'd1 << FractionBits) + 64'd50000000) / 64'd100000000;
      if (scaled[63:DataW] != '0) return '1;
      return scaled[DataW-1:0];
    endfunction

    // y0 + sign * round_half_away(|y1 - y0| * d / w)
    function fixed_t interp(input fixed_t y0, input fixed_t y1, input fixed_t d,
                            input fixed_t w);
      logic [63:0] span;
      logic [63:0] step;
      if (w == '0) return y0;
      span = (y1 >= y0) ? {32'd0, y1} - {32'd0, y0} : {32'd0, y0} - {32'd0, y1};
      step = (span * {32'd0, d} + {32'd0, w} / 2) / {32'd0, w};
      return (y1 >= y0) ? y0 + step[DataW-1:0] : y0 - step[DataW-1:0];
    endfunction

    function lum_word_t predict_lum(input fixed_t m);
      lum_word_t r;
      int        seg;
      fixed_t    d;
      fixed_t    w;
      if (m < mass_q[0]) begin
        r.lpe  = lpe_q[0];
        r.sly  = sly_q[0];
        r.flag = FlagBelow;
      end else if (m >= mass_q[TableEntries-1]) begin
        r.lpe  = lpe_q[TableEntries-1];
        r.sly  = sly_q[TableEntries-1];
        r.flag = FlagAbove;
      end else begin
        seg = 0;
        for (int i = 1; i < TableEntries - 1; i++) begin
          if (mass_q[i] <= m) seg = i;
        end
        w = (mass_q[seg+1] > mass_q[seg]) ? mass_q[seg+1] - mass_q[seg] : '0;
        d = m - mass_q[seg];
        if (d > w) d = w;
        r.lpe  = interp(lpe_q[seg], lpe_q[seg+1], d, w);
        r.sly  = interp(sly_q[seg], sly_q[seg+1], d, w);
        r.flag = FlagInside;
      end
      return r;
    endfunction

    function void note_mass(input fixed_t m);
      lum_word_t r;
      r = predict_lum(m);
      case (r.flag)
        FlagBelow: n_below++;
        FlagAbove: n_above++;
        default:   n_inside++;
      endcase
      pending_lum.push_back(r);
    endfunction

    function void check_word(input fixed_t lpe, input fixed_t sly, input flag_t flag);
      lum_word_t want;
      n_checked++;
      if (pending_lum.size() == 0) begin
        n_bad++;
        if (n_bad <= MaxReports)
          $display("tb_top: unexpected word lpe=%h sly=%h flag=%0d", lpe, sly, flag);
        return;
      end
      want = pending_lum.pop_front();
      if (want.lpe != lpe || want.sly != sly || want.flag != flag) begin
        n_bad++;
        if (n_bad <= MaxReports)
          $display("tb_top: word %0d exp lpe=%h sly=%h flag=%0d got lpe=%h sly=%h flag=%0d",
                   n_checked, want.lpe, want.sly, want.flag, lpe, sly, flag);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  tli_in_if  in_if ();
  tli_out_if out_if ();

  table_interp_luminosity i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  lum_table_checker lum_chk = new();
  int n_masses_in;
  int stall_cycles;

  always #(ClkHalf) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        lum_chk.note_mass(in_if.mass);
        n_masses_in++;
      end
      if (out_if.valid && out_if.ready)
        lum_chk.check_word(out_if.log_pe_luminosity, out_if.log_ionizing_rate,
                           out_if.range_flag);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= StallLimit) begin
          $display("tb_top: no word moved for %0d cycles", StallLimit);
          $display("tb_top: errors");
          $finish;
        end
      end
    end
  end

  // output side: changing stall modes, and one long hold-off to back up the input
  initial begin
    int  mode;
    int  left;
    int  hold;
    bit  held;
    out_if.ready = 1'b0;
    mode = 0;
    left = 0;
    hold = 0;
    held = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!held && n_masses_in >= HoldAt) begin
        held = 1'b1;
        hold = HoldCycles;
      end
      if (hold > 0) begin
        hold--;
        out_if.ready <= 1'b0;
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 3);
          left = $urandom_range(20, 200);
        end
        left--;
        case (mode)
          0:       out_if.ready <= 1'b1;
          1:       out_if.ready <= 1'($urandom_range(0, 1));
          2:       out_if.ready <= ($urandom_range(0, 7) == 0);
          default: out_if.ready <= ((left % 23) < 3);
        endcase
      end
    end
  end

  // call at a falling edge; returns at the falling edge after acceptance
  task automatic push_mass(input fixed_t m);
    in_if.valid <= 1'b1;
    in_if.mass  <= m;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic fixed_t pick_mass();
    int     sel;
    int     seg;
    fixed_t lo;
    fixed_t hi;
    sel = $urandom_range(0, 99);
    lo  = lum_chk.mass_q[0];
    hi  = lum_chk.mass_q[TableEntries-1];
    if (sel < 40) return $urandom_range(hi - 1, lo);
    if (sel < 58) begin
      seg = $urandom_range(0, TableEntries - 2);
      return $urandom_range(lum_chk.mass_q[seg+1] - 1, lum_chk.mass_q[seg]);
    end
    if (sel < 70) begin
      seg = $urandom_range(0, TableEntries - 1);
      return lum_chk.mass_q[seg] + $urandom_range(0, 2) - 1;
    end
    if (sel < 80) return $urandom_range(lo - 1, 0);
    if (sel < 90) return $urandom_range(32'hFFFF_FFFF, hi);
    return $urandom();
  endfunction

  task automatic run_directed();
    fixed_t m[$];
    fixed_t lo;
    fixed_t hi;
    lo = lum_chk.mass_q[0];
    hi = lum_chk.mass_q[TableEntries-1];
    m = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
          lo - 1, lo, lo + 1, lum_chk.mass_q[1] - 1, lum_chk.mass_q[1],
          lum_chk.mass_q[2], lum_chk.mass_q[5], lum_chk.mass_q[10],
          lum_chk.mass_q[12] + (lum_chk.mass_q[13] - lum_chk.mass_q[12]) / 2,
          lum_chk.mass_q[13], lum_chk.mass_q[15] - 1, lum_chk.mass_q[18],
          lum_chk.mass_q[19], lum_chk.mass_q[19] + 1, hi - 2, hi - 1, hi, hi + 1};
    foreach (m[i]) push_mass(m[i]);
  endtask

  task automatic run_random(input int count);
    int burst;
    int gap;
    burst = 0;
    for (int k = 0; k < count; k++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 24);
        case ($urandom_range(0, 3))
          0:       gap = 0;
          1:       gap = $urandom_range(1, 60);
          default: gap = $urandom_range(1, 6);
        endcase
        if (gap > 0) begin
          in_if.valid <= 1'b0;
          repeat (gap) @(negedge clk_i);
        end
      end
      burst--;
      push_mass(pick_mass());
    end
  endtask

  initial begin
    rst_ni       = 1'b0;
    in_if.valid  = 1'b0;
    in_if.mass   = '0;
    n_masses_in  = 0;
    stall_cycles = 0;
    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    run_directed();
    run_random(RandomItems);
    in_if.valid <= 1'b0;
    while (lum_chk.pending_lum.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    $display("tb_top: %0d results compared: %0d interpolated, %0d below, %0d at or above top",
             lum_chk.n_checked, lum_chk.n_inside, lum_chk.n_below, lum_chk.n_above);
    $display("tb_top: %0d bad words, one output hold-off of %0d cycles",
             lum_chk.n_bad, HoldCycles);
    if (lum_chk.n_bad == 0 && lum_chk.pending_lum.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
